// ----- hdl/i2cseq_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and codes for the I2C EEPROM transaction sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

   localparam int ADDR_BITS_DEF = 17;
   localparam int MAX_BURST     = 256;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_WRITE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_WRITE_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_READ_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_READ_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT  = 3'd4;

   localparam logic [7:0]  DEV_WRITE_LOW_RST  = 8'hA0;
   localparam logic [7:0]  DEV_WRITE_HIGH_RST = 8'hA2;
   localparam logic [7:0]  DEV_READ_LOW_RST   = 8'hA1;
   localparam logic [7:0]  DEV_READ_HIGH_RST  = 8'hA3;
   localparam logic [23:0] TIMEOUT_LIMIT_RST  = 24'd10000;

   // input item modes
   localparam logic [2:0] MODE_WRITE   = 3'd0;
   localparam logic [2:0] MODE_READ    = 3'd1;
   localparam logic [2:0] MODE_PROBE   = 3'd2;
   localparam logic [2:0] MODE_WR_BYTE = 3'd3;
   localparam logic [2:0] MODE_DONE    = 3'd4;
   localparam logic [2:0] MODE_TICK    = 3'd5;

   // bus commands
   localparam logic [2:0] CMD_NONE      = 3'd0;
   localparam logic [2:0] CMD_START     = 3'd1;
   localparam logic [2:0] CMD_RESTART   = 3'd2;
   localparam logic [2:0] CMD_SEND      = 3'd3;
   localparam logic [2:0] CMD_RECV_ACK  = 3'd4;
   localparam logic [2:0] CMD_RECV_NACK = 3'd5;
   localparam logic [2:0] CMD_STOP      = 3'd6;

   // status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_ADDR  = 4'd1;
   localparam logic [3:0] ST_COLLISION = 4'd2;
   localparam logic [3:0] ST_NACK_DEVW = 4'd3;
   localparam logic [3:0] ST_NACK_ADRH = 4'd4;
   localparam logic [3:0] ST_NACK_ADRL = 4'd5;
   localparam logic [3:0] ST_NACK_DATA = 4'd6;
   localparam logic [3:0] ST_TIMEOUT   = 4'd7;
   localparam logic [3:0] ST_BUSY      = 4'd8;

   // operation kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_PROBE = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [17:0] mem_addr;
      logic [8:0]  length;
      logic [7:0]  write_byte;
      logic        ack_received;
      logic        collision;
      logic [7:0]  read_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] bus_byte;
      logic       need_data;
      logic [7:0] data_out;
      logic       data_valid;
      logic       done_res;
      logic [3:0] status;
      logic [8:0] byte_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/i2c_eeprom_transaction_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer
// An accepted item's result, where it gives one, is registered and shows on rsp_valid in the cycle after acceptance.
// Throughput: one item per cycle; the input stalls only while a held result is stalled.
// Reset: synchronous, active high; sequencer idle, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_transaction_sequencer #(
   parameter int ADDR_BITS = i2cseq_pkg::ADDR_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire i2cseq_pkg::req_type               req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output i2cseq_pkg::rsp_type                    rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cseq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [i2cseq_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import i2cseq_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_DEVW, PH_ADRH, PH_ADRL, PH_WAITD,
      PH_DATA, PH_RESTART, PH_DEVR, PH_RECV, PH_STOP, PH_PROBE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [1:0]           kind_ff, kind_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [8:0]           len_ff, len_in;
   logic [8:0]           cnt_ff, cnt_in;
   logic [23:0]          ticks_ff, ticks_in;
   logic [3:0]           pend_ff, pend_in;

   logic [7:0]  dev_wl_ff, dev_wh_ff, dev_rl_ff, dev_rh_ff;
   logic [23:0] timeout_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic       req_accept;
   logic       emit;
   rsp_type    res;
   logic       upper;
   logic [7:0] dev_wr_sel, dev_rd_sel;
   logic [8:0] cnt_inc;
   logic [9:0] cnt_inc2;
   logic       bad_cmd;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign upper      = (ADDR_BITS > 16) ? addr_ff[ADDR_BITS-1] : 1'b0;
   assign dev_wr_sel = upper ? dev_wh_ff : dev_wl_ff;
   assign dev_rd_sel = upper ? dev_rh_ff : dev_rl_ff;
   assign cnt_inc    = cnt_ff + 9'd1;
   assign cnt_inc2   = {1'b0, cnt_inc} + 10'd1;
   assign bad_cmd    = (req_data.mem_addr[17:ADDR_BITS] != '0)
                       || (req_data.length == 9'd0)
                       || ({1'b0, req_data.length} > 10'(MAX_BURST));

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      ticks_in = ticks_ff;
      pend_in  = pend_ff;
      emit     = 1'b0;
      res      = '0;
      if (req_accept) begin
         unique case (req_data.mode) inside
            MODE_WRITE, MODE_READ, MODE_PROBE: begin
               if (phase_ff == PH_IDLE) begin
                  kind_in = req_data.mode[1:0];
                  cnt_in  = '0;
                  pend_in = ST_OK;
                  emit    = 1'b1;
                  if (req_data.mode != MODE_PROBE && bad_cmd) begin
                     res.done_res = 1'b1;
                     res.status   = ST_BAD_ADDR;
                     phase_in     = PH_IDLE;
                  end else begin
                     if (req_data.mode != MODE_PROBE) begin
                        addr_in = req_data.mem_addr[ADDR_BITS-1:0];
                        len_in  = req_data.length;
                     end else begin
                        len_in = '0;
                     end
                     res.bus_command = CMD_START;
                     phase_in        = PH_START;
                     ticks_in        = '0;
                  end
               end
            end
            MODE_WR_BYTE: begin
               if (phase_ff == PH_WAITD) begin
                  emit            = 1'b1;
                  res.bus_command = CMD_SEND;
                  res.bus_byte    = req_data.write_byte;
                  phase_in        = PH_DATA;
                  ticks_in        = '0;
               end
            end
            MODE_DONE: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_WAITD) begin
                  emit     = 1'b1;
                  ticks_in = '0;
                  if (req_data.collision) begin
                     res.done_res   = 1'b1;
                     res.status     = ST_COLLISION;
                     res.byte_count = cnt_ff;
                     phase_in       = PH_IDLE;
                     ticks_in       = ticks_ff;
                  end else begin
                     unique case (phase_ff)
                        PH_START: begin
                           res.bus_command = CMD_SEND;
                           if (kind_ff == KIND_PROBE) begin
                              res.bus_byte = dev_wh_ff;
                              phase_in     = PH_PROBE;
                           end else begin
                              res.bus_byte = dev_wr_sel;
                              phase_in     = PH_DEVW;
                           end
                        end
                        PH_PROBE: begin
                           pend_in         = req_data.ack_received ? ST_OK : ST_BUSY;
                           res.bus_command = CMD_STOP;
                           phase_in        = PH_STOP;
                        end
                        PH_DEVW, PH_ADRH, PH_ADRL, PH_DATA, PH_DEVR: begin
                           if (!req_data.ack_received) begin
                              res.done_res   = 1'b1;
                              res.byte_count = cnt_ff;
                              phase_in       = PH_IDLE;
                              ticks_in       = ticks_ff;
                              unique case (phase_ff)
                                 PH_DEVW: res.status = ST_NACK_DEVW;
                                 PH_ADRH: res.status = ST_NACK_ADRH;
                                 PH_ADRL: res.status = ST_NACK_ADRL;
                                 default: res.status = ST_NACK_DATA;
                              endcase
                           end else begin
                              unique case (phase_ff)
                                 PH_DEVW: begin
                                    res.bus_command = CMD_SEND;
                                    res.bus_byte    = addr_ff[15:8];
                                    phase_in        = PH_ADRH;
                                 end
                                 PH_ADRH: begin
                                    res.bus_command = CMD_SEND;
                                    res.bus_byte    = addr_ff[7:0];
                                    phase_in        = PH_ADRL;
                                 end
                                 PH_ADRL: begin
                                    if (kind_ff == KIND_WRITE) begin
                                       res.need_data = 1'b1;
                                       phase_in      = PH_WAITD;
                                       ticks_in      = ticks_ff;
                                    end else begin
                                       res.bus_command = CMD_RESTART;
                                       phase_in        = PH_RESTART;
                                    end
                                 end
                                 PH_DATA: begin
                                    cnt_in = cnt_inc;
                                    if (cnt_inc >= len_ff) begin
                                       pend_in         = ST_OK;
                                       res.bus_command = CMD_STOP;
                                       phase_in        = PH_STOP;
                                    end else begin
                                       res.need_data = 1'b1;
                                       phase_in      = PH_WAITD;
                                       ticks_in      = ticks_ff;
                                    end
                                 end
                                 default: begin
                                    res.bus_command = (len_ff <= 9'd1) ? CMD_RECV_NACK
                                                                       : CMD_RECV_ACK;
                                    phase_in        = PH_RECV;
                                 end
                              endcase
                           end
                        end
                        PH_RESTART: begin
                           res.bus_command = CMD_SEND;
                           res.bus_byte    = dev_rd_sel;
                           phase_in        = PH_DEVR;
                        end
                        PH_RECV: begin
                           cnt_in         = cnt_inc;
                           res.data_out   = req_data.read_byte;
                           res.data_valid = 1'b1;
                           if (cnt_inc >= len_ff) begin
                              pend_in         = ST_OK;
                              res.bus_command = CMD_STOP;
                              phase_in        = PH_STOP;
                           end else begin
                              res.bus_command = (cnt_inc2 >= {1'b0, len_ff}) ? CMD_RECV_NACK
                                                                            : CMD_RECV_ACK;
                              phase_in        = PH_RECV;
                           end
                        end
                        PH_STOP: begin
                           res.done_res   = 1'b1;
                           res.status     = pend_ff;
                           res.byte_count = cnt_ff;
                           phase_in       = PH_IDLE;
                           ticks_in       = ticks_ff;
                        end
                        default: begin
                           emit     = 1'b0;
                           phase_in = PH_IDLE;
                           ticks_in = ticks_ff;
                        end
                     endcase
                  end
               end
            end
            MODE_TICK: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_WAITD) begin
                  if (ticks_ff >= timeout_ff) begin
                     emit           = 1'b1;
                     res.done_res   = 1'b1;
                     res.byte_count = cnt_ff;
                     res.status     = (phase_ff == PH_STOP && kind_ff == KIND_WRITE)
                                      ? pend_ff : ST_TIMEOUT;
                     phase_in       = PH_IDLE;
                  end else begin
                     ticks_in = ticks_ff + 24'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         kind_ff      <= KIND_WRITE;
         addr_ff      <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         ticks_ff     <= '0;
         pend_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
         dev_wl_ff    <= DEV_WRITE_LOW_RST;
         dev_wh_ff    <= DEV_WRITE_HIGH_RST;
         dev_rl_ff    <= DEV_READ_LOW_RST;
         dev_rh_ff    <= DEV_READ_HIGH_RST;
         timeout_ff   <= TIMEOUT_LIMIT_RST;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         ticks_ff     <= ticks_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DEV_WRITE_LOW:  dev_wl_ff  <= csr_wdata[7:0];
               CSR_DEV_WRITE_HIGH: dev_wh_ff  <= csr_wdata[7:0];
               CSR_DEV_READ_LOW:   dev_rl_ff  <= csr_wdata[7:0];
               CSR_DEV_READ_HIGH:  dev_rh_ff  <= csr_wdata[7:0];
               CSR_TIMEOUT_LIMIT:  timeout_ff <= csr_wdata[23:0];
               default: begin
               end
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a finishing result always leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      emit && res.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after finishing transfer");

   // only a write burst waits for data bytes
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAITD |-> kind_ff == KIND_WRITE)
      else $error("waiting for data outside a write");

   // byte count never passes the burst length
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= len_ff)
      else $error("byte count beyond burst length");

   // a new result is only loaded when the result register can take it
   assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
